// File: hw/rtl/lbp_3x3_code_histogram_top_defines.svh
// assertion macros used by the lbp histogram checker
`ifndef LBP_3X3_CODE_HISTOGRAM_TOP_DEFINES_SVH
`define LBP_3X3_CODE_HISTOGRAM_TOP_DEFINES_SVH

// same-cycle implication, off while reset is high
`define LBPH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define LBPH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also runs through reset
`define LBPH_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/lbph_pkg.sv
// shared types, constants and helpers of the lbp code histogram block
package lbph_pkg;

   localparam int LBPH_MAX_WIDTH  = 1024;
   localparam int LBPH_MAX_HEIGHT = 1024;
   localparam int HIST_BINS       = 256;

   localparam int POS_W     = 10;
   localparam int DIM_W     = 11;
   localparam int LIM_W     = 13;
   localparam int PIX_W     = 8;
   localparam int CODE_W    = 8;
   localparam int BIN_W     = 8;
   localparam int COUNT_W   = 21;
   localparam int CSR_IDX_W = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [1:0] OP_PUSH       = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_READ_CLEAR = 2'd2;

   localparam logic KIND_CODE  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 4'd1;

   localparam logic [DIM_W-1:0] DIM_MIN            = 11'd3;
   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

   localparam logic [POS_W-1:0] BORDER_POS = 10'd2;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [PIX_W-1:0] pixel_value;
      logic [BIN_W-1:0] bin_index;
   } lbph_req_type;

   typedef struct packed {
      logic               result_kind;
      logic [CODE_W-1:0]  pattern_code;
      logic [POS_W-1:0]   centre_row;
      logic [POS_W-1:0]   centre_col;
      logic [COUNT_W-1:0] bin_count;
   } lbph_rsp_type;

   typedef struct packed {
      logic rd_en;
      logic shift_en;
   } lbph_line_ctl_type;

   typedef struct packed {
      logic advance;
      logic wr_en;
      logic clear;
   } lbph_hist_ctl_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input logic [LIM_W-1:0] limit);
      if (value < DIM_MIN) begin
         return DIM_MIN;
      end else if ({2'b00, value} > limit) begin
         return limit[DIM_W-1:0];
      end
      return value;
   endfunction

endpackage

// File: hw/rtl/lbp_3x3_code_histogram_top.sv
// top level of the 3x3 lbp coder with code histogram
// a result beat reaches rsp through stage one, stage two and the rsp register after its request beat is accepted
// one request beat per cycle; the pipeline stalls as a whole only while rsp is held
// stage one reads the line memories, stage two does the histogram read-modify-write
// reset clears positions, pipeline, window and histogram valid bits at once
// line memories keep their contents and frame size returns to 640 by 480
module lbp_3x3_code_histogram_top #(
   parameter int MAX_WIDTH = lbph_pkg::LBPH_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lbph_pkg::lbph_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lbph_pkg::lbph_rsp_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lbph_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lbph_pkg::DIM_W-1:0]        csr_data
);
   import lbph_pkg::*;

   localparam logic [LIM_W-1:0] WIDTH_LIM  = LIM_W'(MAX_WIDTH);
   localparam logic [LIM_W-1:0] HEIGHT_LIM = LIM_W'(LBPH_MAX_HEIGHT);

   logic advance;
   logic accept;
   logic push0;
   logic csr_hit;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] col_next;
   logic [DIM_W-1:0] row_next;

   // stage one
   logic             v1_ff, v1_in;
   logic [1:0]       op1_ff;
   logic [PIX_W-1:0] px1_ff;
   logic [BIN_W-1:0] bin1_ff;
   logic             emit1_ff;
   logic [POS_W-1:0] crow1_ff;
   logic [POS_W-1:0] ccol1_ff;
   logic [POS_W-1:0] lcol1_ff;

   // stage two
   logic              res2_ff, res2_in;
   logic              hwr2_ff, hwr2_in;
   logic              kind2_ff;
   logic              clr2_ff;
   logic [CODE_W-1:0] code2_ff;
   logic [POS_W-1:0]  crow2_ff;
   logic [POS_W-1:0]  ccol2_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   lbph_rsp_type rsp_data_ff;

   logic              s1_push;
   logic [CODE_W-1:0] code1;
   logic [BIN_W-1:0]  hist_addr;
   logic [COUNT_W-1:0] old_count;

   lbph_line_ctl_type line_ctl;
   lbph_hist_ctl_type hist_ctl;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign push0     = accept && (req_data.opcode == OP_PUSH);
   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid &&
                      ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT));

   assign col_next = {1'b0, col_ff} + 1'b1;
   assign row_next = {1'b0, row_ff} + 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_valid && (csr_index == CSR_FRAME_WIDTH)) begin
         width_in = clamp_dim(csr_data, WIDTH_LIM);
      end
      if (csr_valid && (csr_index == CSR_FRAME_HEIGHT)) begin
         height_in = clamp_dim(csr_data, HEIGHT_LIM);
      end
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (push0) begin
         if (col_next >= width_ff) begin
            col_in = '0;
            row_in = (row_next >= height_ff) ? '0 : row_next[POS_W-1:0];
         end else begin
            col_in = col_next[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_dim(FRAME_WIDTH_RESET, WIDTH_LIM);
         height_ff <= clamp_dim(FRAME_HEIGHT_RESET, HEIGHT_LIM);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op1_ff   <= req_data.opcode;
         px1_ff   <= req_data.pixel_value;
         bin1_ff  <= req_data.bin_index;
         emit1_ff <= (row_ff >= BORDER_POS) && (col_ff >= BORDER_POS);
         crow1_ff <= row_ff - 1'b1;
         ccol1_ff <= col_ff - 1'b1;
         lcol1_ff <= col_ff;
      end
   end

   assign s1_push = v1_ff && (op1_ff == OP_PUSH);

   assign line_ctl.rd_en    = advance;
   assign line_ctl.shift_en = advance && s1_push;

   lbph_line_unit #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line (
      .clock  (clock),
      .reset  (reset),
      .ctl    (line_ctl),
      .rd_col (col_ff),
      .wr_col (lcol1_ff),
      .pixel  (px1_ff),
      .code   (code1)
   );

   assign hist_addr = (op1_ff == OP_PUSH) ? code1 : bin1_ff;

   assign hist_ctl.advance = advance;
   assign hist_ctl.wr_en   = advance && hwr2_ff;
   assign hist_ctl.clear   = clr2_ff;

   lbph_hist_unit u_hist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (hist_ctl),
      .rd_addr   (hist_addr),
      .old_count (old_count)
   );

   always_comb begin
      v1_in        = v1_ff;
      res2_in      = res2_ff;
      hwr2_in      = hwr2_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         v1_in   = accept;
         res2_in = v1_ff && ((op1_ff == OP_READ) || (op1_ff == OP_READ_CLEAR) ||
                             ((op1_ff == OP_PUSH) && emit1_ff));
         hwr2_in = v1_ff && ((op1_ff == OP_READ_CLEAR) ||
                             ((op1_ff == OP_PUSH) && emit1_ff));
         rsp_valid_in = res2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         res2_ff      <= 1'b0;
         hwr2_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         res2_ff      <= res2_in;
         hwr2_ff      <= hwr2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind2_ff <= (op1_ff == OP_PUSH) ? KIND_CODE : KIND_COUNT;
         clr2_ff  <= (op1_ff == OP_READ_CLEAR);
         code2_ff <= code1;
         crow2_ff <= crow1_ff;
         ccol2_ff <= ccol1_ff;
         if (kind2_ff == KIND_CODE) begin
            rsp_data_ff.result_kind  <= KIND_CODE;
            rsp_data_ff.pattern_code <= code2_ff;
            rsp_data_ff.centre_row   <= crow2_ff;
            rsp_data_ff.centre_col   <= ccol2_ff;
            rsp_data_ff.bin_count    <= '0;
         end else begin
            rsp_data_ff.result_kind  <= KIND_COUNT;
            rsp_data_ff.pattern_code <= '0;
            rsp_data_ff.centre_row   <= '0;
            rsp_data_ff.centre_col   <= '0;
            rsp_data_ff.bin_count    <= old_count;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/lbph_line_unit.sv
// line memories, 3x3 window and pattern code compare
module lbph_line_unit #(
   parameter int MAX_WIDTH = lbph_pkg::LBPH_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lbph_pkg::lbph_line_ctl_type     ctl,
   input  logic [lbph_pkg::POS_W-1:0]      rd_col,
   input  logic [lbph_pkg::POS_W-1:0]      wr_col,
   input  logic [lbph_pkg::PIX_W-1:0]      pixel,
   output logic [lbph_pkg::CODE_W-1:0]     code
);
   import lbph_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [PIX_W-1:0] upper_mem_ff [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem_ff [MAX_WIDTH];
   logic [PIX_W-1:0] top_ff;
   logic [PIX_W-1:0] mid_ff;
   logic [PIX_W-1:0] win_ff [6];
   logic [PIX_W-1:0] win_in [6];
   logic [PIX_W-1:0] centre;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;

   assign rd_addr = AW'(rd_col);
   assign wr_addr = AW'(wr_col);

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         top_ff <= upper_mem_ff[rd_addr];
         mid_ff <= middle_mem_ff[rd_addr];
      end
      if (ctl.shift_en) begin
         upper_mem_ff[wr_addr]  <= mid_ff;
         middle_mem_ff[wr_addr] <= pixel;
      end
   end

   always_comb begin
      win_in = win_ff;
      if (ctl.shift_en) begin
         win_in[0] = win_ff[3];
         win_in[1] = win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = top_ff;
         win_in[4] = mid_ff;
         win_in[5] = pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         win_ff <= win_in;
      end
   end

   // clockwise from top-left
   assign centre  = win_ff[4];
   assign code[0] = (win_ff[0] >= centre);
   assign code[1] = (win_ff[3] >= centre);
   assign code[2] = (top_ff >= centre);
   assign code[3] = (mid_ff >= centre);
   assign code[4] = (pixel >= centre);
   assign code[5] = (win_ff[5] >= centre);
   assign code[6] = (win_ff[2] >= centre);
   assign code[7] = (win_ff[1] >= centre);

endmodule

// File: hw/rtl/lbph_hist_unit.sv
// histogram memory with read-modify-write and write forwarding
module lbph_hist_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  lbph_pkg::lbph_hist_ctl_type      ctl,
   input  logic [lbph_pkg::BIN_W-1:0]       rd_addr,
   output logic [lbph_pkg::COUNT_W-1:0]     old_count
);
   import lbph_pkg::*;

   logic [COUNT_W-1:0]   hist_mem_ff [HIST_BINS];
   logic [HIST_BINS-1:0] bin_vld_ff;
   logic [HIST_BINS-1:0] bin_vld_in;
   logic [COUNT_W-1:0]   rd_data_ff;
   logic                 rd_vld_ff;
   logic                 rd_vld_in;
   logic [BIN_W-1:0]     wr_addr_ff;
   logic                 fwd_hit_ff;
   logic                 fwd_hit_in;
   logic [COUNT_W-1:0]   fwd_data_ff;
   logic [COUNT_W-1:0]   wr_data;

   assign old_count = fwd_hit_ff ? fwd_data_ff : (rd_vld_ff ? rd_data_ff : '0);

   // saturating increment, or zero on read and clear
   always_comb begin
      if (ctl.clear) begin
         wr_data = '0;
      end else if (old_count == COUNT_MAX) begin
         wr_data = old_count;
      end else begin
         wr_data = old_count + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         rd_data_ff  <= hist_mem_ff[rd_addr];
         wr_addr_ff  <= rd_addr;
         fwd_data_ff <= wr_data;
      end
      if (ctl.wr_en) begin
         hist_mem_ff[wr_addr_ff] <= wr_data;
      end
   end

   always_comb begin
      bin_vld_in = bin_vld_ff;
      rd_vld_in  = rd_vld_ff;
      fwd_hit_in = fwd_hit_ff;
      if (ctl.advance) begin
         rd_vld_in  = bin_vld_ff[rd_addr];
         fwd_hit_in = ctl.wr_en && (wr_addr_ff == rd_addr);
      end
      if (ctl.wr_en) begin
         bin_vld_in[wr_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         bin_vld_ff <= bin_vld_in;
         rd_vld_ff  <= rd_vld_in;
         fwd_hit_ff <= fwd_hit_in;
      end
   end

endmodule

// File: hw/rtl/lbph_checker.sv
// port-level checks of the lbp histogram top, bound to it
`include "lbp_3x3_code_histogram_top_defines.svh"

module lbph_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input lbph_pkg::lbph_rsp_type rsp_data
);
   import lbph_pkg::*;

   `LBPH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")
   `LBPH_ASSERT_SAME(a_stall_input, rsp_valid && !rsp_ready, !req_ready, "request taken while rsp stalled")
   `LBPH_ASSERT_SAME(a_centre_interior, rsp_valid && (rsp_data.result_kind == KIND_CODE), (rsp_data.centre_row != '0) && (rsp_data.centre_col != '0), "code beat for a border centre")
   `LBPH_ASSERT_ALWAYS(a_reset_quiet, reset, !rsp_valid, "rsp valid right after reset")

endmodule

bind lbp_3x3_code_histogram_top lbph_checker u_lbph_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the 3x3 lbp coder with code histogram
module tb_top;
   import lbph_pkg::*;

   localparam int CLK_HALF        = 6;
   localparam int RESET_CYCLES    = 7;
   localparam int STALL_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int REPORT_LIMIT    = 10;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int WIDE_COLS       = 240;
   localparam int TALL_ROWS       = 100;

   localparam logic [1:0]           OP_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd15;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   lbph_req_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   lbph_rsp_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_data  = '0;

   // window and histogram shadow
   bit [PIX_W-1:0]   upper_row  [LBPH_MAX_WIDTH];
   bit [PIX_W-1:0]   middle_row [LBPH_MAX_WIDTH];
   bit [PIX_W-1:0]   win_cols   [6];
   bit [COUNT_W-1:0] bin_tally  [HIST_BINS];
   int               col_pos = 0;
   int               row_pos = 0;
   bit [DIM_W-1:0]   width_reg  = FRAME_WIDTH_RESET;
   bit [DIM_W-1:0]   height_reg = FRAME_HEIGHT_RESET;

   lbph_rsp_type pending_results [$];
   int bad_beats    = 0;
   int quiet_cycles = 0;
   int tx_idle_pct  = 6;
   int rx_idle_pct  = 77;
   int tx_calm      = 0;
   int rx_calm      = 0;

   lbp_3x3_code_histogram_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic int fit_dim(input int value, input int hi);
      if (value < 3) begin
         return 3;
      end else if (value > hi) begin
         return hi;
      end
      return value;
   endfunction

   task automatic lbp_window_step(input lbph_req_type beat);
      lbph_rsp_type   res;
      bit [PIX_W-1:0] top;
      bit [PIX_W-1:0] mid;
      bit [PIX_W-1:0] ctr;
      bit [CODE_W-1:0] code;
      int             w;
      int             h;
      res = '0;
      case (beat.opcode)
         OP_READ, OP_READ_CLEAR: begin
            res.result_kind = KIND_COUNT;
            res.bin_count   = bin_tally[beat.bin_index];
            if (beat.opcode == OP_READ_CLEAR) begin
               bin_tally[beat.bin_index] = '0;
            end
            pending_results.push_back(res);
         end
         OP_PUSH: begin
            w   = fit_dim(int'(width_reg), LBPH_MAX_WIDTH);
            h   = fit_dim(int'(height_reg), LBPH_MAX_HEIGHT);
            top = upper_row[col_pos];
            mid = middle_row[col_pos];
            if (row_pos >= 2 && col_pos >= 2) begin
               ctr  = win_cols[4];
               // bit 0 top-left, clockwise to bit 7 middle-left
               code = {win_cols[1] >= ctr, win_cols[2] >= ctr, win_cols[5] >= ctr,
                       beat.pixel_value >= ctr, mid >= ctr, top >= ctr,
                       win_cols[3] >= ctr, win_cols[0] >= ctr};
               if (bin_tally[code] != COUNT_MAX) begin
                  bin_tally[code] = bin_tally[code] + 1'b1;
               end
               res.result_kind  = KIND_CODE;
               res.pattern_code = code;
               res.centre_row   = POS_W'(row_pos - 1);
               res.centre_col   = POS_W'(col_pos - 1);
               pending_results.push_back(res);
            end
            win_cols[0] = win_cols[3];
            win_cols[1] = win_cols[4];
            win_cols[2] = win_cols[5];
            win_cols[3] = top;
            win_cols[4] = mid;
            win_cols[5] = beat.pixel_value;
            upper_row[col_pos]  = mid;
            middle_row[col_pos] = beat.pixel_value;
            col_pos++;
            if (col_pos >= w) begin
               col_pos = 0;
               row_pos++;
               if (row_pos >= h) begin
                  row_pos = 0;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         lbp_window_step(req_data);
      end
   end

   always @(posedge clock) begin : check_rsp
      lbph_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            bad_beats++;
            if (bad_beats <= REPORT_LIMIT) begin
               $display("unexpected rsp beat: kind %0d code %0h row %0d col %0d count %0d",
                        rsp_data.result_kind, rsp_data.pattern_code, rsp_data.centre_row,
                        rsp_data.centre_col, rsp_data.bin_count);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_kind !== want.result_kind ||
                rsp_data.pattern_code !== want.pattern_code ||
                rsp_data.centre_row !== want.centre_row ||
                rsp_data.centre_col !== want.centre_col ||
                rsp_data.bin_count !== want.bin_count) begin
               bad_beats++;
               if (bad_beats <= REPORT_LIMIT) begin
                  $display("rsp mismatch: expected kind %0d code %0h row %0d col %0d count %0d",
                           want.result_kind, want.pattern_code, want.centre_row,
                           want.centre_col, want.bin_count);
                  $display("              got      kind %0d code %0h row %0d col %0d count %0d",
                           rsp_data.result_kind, rsp_data.pattern_code, rsp_data.centre_row,
                           rsp_data.centre_col, rsp_data.bin_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver back-pressure with occasional calm stretches
   always @(negedge clock) begin
      if (rx_calm > 0) begin
         rx_calm--;
         rsp_ready <= 1'b1;
      end else begin
         if ($urandom_range(0, 99) == 0) begin
            rx_calm = $urandom_range(20, 60);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic send_req(input lbph_req_type beat);
      while (tx_calm == 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      if (tx_calm > 0) begin
         tx_calm--;
      end else if ($urandom_range(0, 99) == 0) begin
         tx_calm = $urandom_range(20, 60);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic push_px(input bit [PIX_W-1:0] px);
      lbph_req_type beat;
      beat.opcode      = OP_PUSH;
      beat.pixel_value = px;
      beat.bin_index   = BIN_W'($urandom_range(0, 255));
      send_req(beat);
   endtask

   task automatic read_bin(input logic [1:0] op, input bit [BIN_W-1:0] bin);
      lbph_req_type beat;
      beat.opcode      = op;
      beat.pixel_value = PIX_W'($urandom_range(0, 255));
      beat.bin_index   = bin;
      send_req(beat);
   endtask

   task automatic send_unused_op();
      lbph_req_type beat;
      beat.opcode      = OP_UNUSED;
      beat.pixel_value = PIX_W'($urandom_range(0, 255));
      beat.bin_index   = BIN_W'($urandom_range(0, 255));
      send_req(beat);
   endtask

   // half the pixels near one level so ties are common
   function automatic bit [PIX_W-1:0] random_px();
      if ($urandom_range(0, 1) == 0) begin
         return PIX_W'($urandom_range(0, 255));
      end
      return PIX_W'($urandom_range(120, 123));
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim(input int hi_small);
      int p;
      p = $urandom_range(0, 99);
      if (p < 10) begin
         return DIM_W'($urandom_range(0, 2));
      end else if (p < 18) begin
         return DIM_W'(1024);
      end else if (p < 25) begin
         return DIM_W'($urandom_range(1025, 2047));
      end
      return DIM_W'($urandom_range(3, hi_small));
   endfunction

   // drop valid and wait for the pipeline to drain
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_FRAME_WIDTH) begin
         width_reg = value;
         col_pos   = 0;
         row_pos   = 0;
      end else if (idx == CSR_FRAME_HEIGHT) begin
         height_reg = value;
         col_pos    = 0;
         row_pos    = 0;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_reset_bins();
      read_bin(OP_READ, 8'd0);
      read_bin(OP_READ_CLEAR, 8'd255);
   endtask

   task automatic test_small_frames();
      bit [PIX_W-1:0] frame_b [9] = '{10, 20, 30, 40, 255, 50, 60, 70, 255};
      settle();
      // both below the minimum, so a 3x3 frame
      write_csr(CSR_FRAME_WIDTH, 11'd0);
      write_csr(CSR_FRAME_HEIGHT, 11'd2);
      // flat frame: every neighbour ties the centre
      repeat (9) push_px(8'd0);
      // bright centre, only the bottom-right neighbour reaches it
      for (int i = 0; i < 9; i++) begin
         if (i == 4) begin
            send_unused_op();
         end
         push_px(frame_b[i]);
      end
      read_bin(OP_READ, 8'hFF);
      read_bin(OP_READ_CLEAR, 8'hFF);
      read_bin(OP_READ, 8'hFF);
      read_bin(OP_READ_CLEAR, 8'h10);
   endtask

   task automatic test_wide_frame();
      settle();
      write_csr(CSR_FRAME_WIDTH, DIM_W'(WIDE_COLS));
      write_csr(CSR_FRAME_HEIGHT, 11'd3);
      repeat (3 * WIDE_COLS + 3) push_px(random_px());
      repeat (4) read_bin(OP_READ_CLEAR, BIN_W'($urandom_range(0, 255)));
   endtask

   task automatic test_tall_frame();
      settle();
      write_csr(CSR_FRAME_WIDTH, 11'd3);
      write_csr(CSR_FRAME_HEIGHT, DIM_W'(TALL_ROWS));
      repeat (3 * TALL_ROWS + 9) push_px(random_px());
      repeat (4) read_bin(OP_READ, BIN_W'($urandom_range(0, 255)));
      settle();
      write_csr(CSR_FRAME_HEIGHT, 11'd2047);
      repeat (30) push_px(random_px());
   endtask

   task automatic test_random_stream(input int first_phase, input int last_phase);
      int counted;
      int pick;
      for (int ph = first_phase; ph <= last_phase; ph++) begin
         settle();
         if (ph == 5) begin
            write_csr(CSR_UNUSED, DIM_W'($urandom_range(0, 2047)));
         end
         write_csr(CSR_FRAME_WIDTH, pick_dim(12));
         write_csr(CSR_FRAME_HEIGHT, pick_dim(6));
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               send_unused_op();
            end else if (pick < 13) begin
               read_bin((pick < 8) ? OP_READ : OP_READ_CLEAR, BIN_W'($urandom_range(0, 255)));
               counted++;
            end else begin
               push_px(random_px());
               counted++;
            end
            // now and then hold off until the block has drained
            if ($urandom_range(0, 99) == 0) begin
               settle();
            end
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_bins();
      test_small_frames();
      test_wide_frame();
      test_random_stream(0, 3);
      tx_idle_pct = 77;
      rx_idle_pct = 6;
      test_tall_frame();
      test_random_stream(4, 7);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_stream(8, 11);
      settle();
      if (bad_beats == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
